>>> rtl/fragment_reassembly_tracker_assert.svh
// Assertion macros for the fragment reassembly tracker.
// Used by the top level only; no other dependencies.
`ifndef FRAGMENT_REASSEMBLY_TRACKER_ASSERT_SVH
`define FRAGMENT_REASSEMBLY_TRACKER_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define FRT_ASSERT_IMPL(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define FRT_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

>>> rtl/frt_pkg.sv
// Shared types and constants for the fragment reassembly tracker.
// No dependencies.
package frt_pkg;
    localparam int SLOTS     = 8;
    localparam int MAX_FRAGS = 64;
    localparam int SLOT_W    = 3;
    localparam int FRAG_W    = 6;
    localparam int CNT_W     = 7;
    localparam int QDEPTH    = 2;

    localparam logic [2:0] ST_STORED   = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_TOOMANY  = 3'd5;

    localparam logic [1:0] REG_CHUNK = 2'd0;
    localparam logic [1:0] REG_STALE = 2'd1;
    localparam logic [1:0] REG_SWEEP = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [15:0] image_id;
        logic [15:0] frag_index;
        logic [15:0] frag_total;
        logic [15:0] image_bytes;
        logic [15:0] payload_bytes;
    } frt_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] write_offset;
        logic [15:0] write_length;
        logic [2:0]  slot_index;
        logic        image_complete;
        logic [15:0] done_bytes;
        logic [31:0] latency_ticks;
    } frt_out_t;

    // Header as queued between front and back: timestamp and offset resolved.
    typedef struct packed {
        logic [15:0] image_id;
        logic [15:0] frag_index;
        logic [15:0] frag_total;
        logic [15:0] image_bytes;
        logic [15:0] payload_bytes;
        logic [31:0] offset;
        logic [31:0] time_now;
        logic        do_sweep;
    } frt_job_t;
endpackage

>>> rtl/frt_front.sv
// Front end: takes transactions, counts ticks, computes offset and sweep decision.
// Depends on frt_pkg.
module frt_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  frt_pkg::frt_in_t in_item,
    input  logic             q_full,
    input  logic [15:0]      chunk_bytes,
    input  logic [15:0]      sweep_ticks,
    output logic             busy,
    output logic             job_push,
    output frt_pkg::frt_job_t job
);
    import frt_pkg::*;

    logic [31:0] time_reg, time_next;
    logic [31:0] sweep_reg, sweep_next;
    logic        accept;
    logic [31:0] since;

    assign busy   = q_full;
    assign accept = start && !busy;
    assign since  = time_reg - sweep_reg;

    // Tick counting and sweep timing
    always_comb
    begin
        time_next  = time_reg;
        sweep_next = sweep_reg;
        job_push   = 1'b0;
        if (accept)
        begin
            if (in_item.mode)
            begin
                time_next = time_reg + 32'd1;
            end
            else
            begin
                job_push = 1'b1;
                if (since > {16'd0, sweep_ticks})
                begin
                    sweep_next = time_reg;
                end
            end
        end
    end

    // Job payload; offset product is 16x16
    always_comb
    begin
        job.image_id      = in_item.image_id;
        job.frag_index    = in_item.frag_index;
        job.frag_total    = in_item.frag_total;
        job.image_bytes   = in_item.image_bytes;
        job.payload_bytes = in_item.payload_bytes;
        job.offset        = in_item.frag_index * chunk_bytes;
        job.time_now      = time_reg;
        job.do_sweep      = since > {16'd0, sweep_ticks};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg  <= '0;
            sweep_reg <= '0;
        end
        else
        begin
            time_reg  <= time_next;
            sweep_reg <= sweep_next;
        end
    end
endmodule

>>> rtl/frt_queue.sv
// Two-entry job queue between front and back ends.
// Depends on frt_pkg.
module frt_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  frt_pkg::frt_job_t push_job,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output frt_pkg::frt_job_t head
);
    import frt_pkg::*;

    frt_job_t    mem_reg [QDEPTH];
    logic        wr_reg, wr_next;
    logic        rd_reg, rd_next;
    logic [1:0]  cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'(QDEPTH));
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

>>> rtl/frt_back.sv
// Back end: slot table lookup, allocation, bitmap update and result register.
// Depends on frt_pkg.
module frt_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  frt_pkg::frt_job_t job,
    input  logic [15:0]       stale_ticks,
    output logic              pop,
    output logic              done,
    output frt_pkg::frt_out_t result
);
    import frt_pkg::*;

    logic [SLOTS-1:0]     valid_reg, valid_next;
    logic [15:0]          img_reg   [SLOTS];
    logic [15:0]          total_reg [SLOTS];
    logic [15:0]          bytes_reg [SLOTS];
    logic [CNT_W-1:0]     got_reg   [SLOTS];
    logic [MAX_FRAGS-1:0] map_reg   [SLOTS];
    logic [31:0]          first_reg [SLOTS];
    logic [31:0]          last_reg  [SLOTS];
    logic                 done_reg;
    frt_out_t             res_reg, res_next;

    logic [SLOTS-1:0]  live, hit;
    logic              found, has_free, use_slot, alloc;
    logic [SLOT_W-1:0] hit_idx, free_idx, s_idx;
    logic [15:0]       s_total, s_bytes;
    logic [CNT_W-1:0]  s_got, got_new;
    logic [MAX_FRAGS-1:0] s_map;
    logic [31:0]       s_first;
    logic              stored;
    logic [16:0]       end_pos;

    assign pop    = job_valid;
    assign done   = done_reg;
    assign result = res_reg;

    // Sweep, match and free-slot search
    always_comb
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            live[s] = valid_reg[s] && !(job.do_sweep &&
                      (job.time_now - last_reg[s]) > {16'd0, stale_ticks});
            hit[s]  = live[s] && (img_reg[s] == job.image_id);
        end
        found = 1'b0; hit_idx = '0;
        has_free = 1'b0; free_idx = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (hit[s])
            begin
                found = 1'b1; hit_idx = SLOT_W'(s);
            end
            if (!live[s])
            begin
                has_free = 1'b1; free_idx = SLOT_W'(s);
            end
        end
    end

    // Classification and result
    always_comb
    begin
        alloc    = !found && (job.frag_total <= 16'(MAX_FRAGS)) && has_free;
        use_slot = found || alloc;
        s_idx    = found ? hit_idx : free_idx;
        s_total  = alloc ? job.frag_total : total_reg[s_idx];
        s_bytes  = alloc ? job.image_bytes : bytes_reg[s_idx];
        s_got    = alloc ? '0 : got_reg[s_idx];
        s_map    = alloc ? '0 : map_reg[s_idx];
        s_first  = alloc ? job.time_now : first_reg[s_idx];
        end_pos  = 17'(job.offset) + {1'b0, job.payload_bytes};
        stored   = 1'b0;
        res_next = '0;
        if (!found && job.frag_total > 16'(MAX_FRAGS))
            res_next.status = ST_TOOMANY;
        else if (!use_slot)
            res_next.status = ST_FULL;
        else if (job.frag_index >= s_total)
            res_next.status = ST_RANGE;
        else if (s_map[job.frag_index[FRAG_W-1:0]])
            res_next.status = ST_DUP;
        else if (job.offset[31:16] != 16'd0 || end_pos > {1'b0, s_bytes})
            res_next.status = ST_OVERFLOW;
        else
        begin
            res_next.status       = ST_STORED;
            res_next.write_offset = job.offset[15:0];
            res_next.write_length = job.payload_bytes;
            stored                = 1'b1;
        end
        got_new = s_got + CNT_W'(stored);
        if (use_slot)
        begin
            res_next.slot_index = s_idx;
            if ({9'd0, got_new} == s_total)
            begin
                res_next.image_complete = 1'b1;
                res_next.done_bytes     = s_bytes;
                res_next.latency_ticks  = job.time_now - s_first;
            end
        end
        valid_next = live;
        if (use_slot)
            valid_next[s_idx] = !res_next.image_complete;
        if (!job_valid)
            valid_next = valid_reg;
    end

    // Slot payload storage
    always_ff @(posedge clk)
    begin
        if (job_valid && use_slot)
        begin
            img_reg[s_idx]   <= job.image_id;
            total_reg[s_idx] <= s_total;
            bytes_reg[s_idx] <= s_bytes;
            got_reg[s_idx]   <= got_new;
            first_reg[s_idx] <= s_first;
            last_reg[s_idx]  <= job.time_now;
            map_reg[s_idx]   <= s_map | (stored ?
                (MAX_FRAGS'(1) << job.frag_index[FRAG_W-1:0]) : '0);
        end
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= job_valid;
        end
    end
endmodule

>>> rtl/fragment_reassembly_tracker.sv
// Fragment reassembly tracker: 8-slot image table with fragment bitmaps.
// A header's result is registered in the queue, then in the slot table's result register.
// Throughput: one transaction per cycle while busy is low; ticks produce no result.
// busy rises only when the two-entry queue is full.
// Reset (rst_n, async low) clears the table valid bits, time and registers.
// Depends on frt_pkg, frt_front, frt_queue, frt_back and the assertion header.
`include "fragment_reassembly_tracker_assert.svh"
module fragment_reassembly_tracker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  frt_pkg::frt_in_t in_item,
    output logic             busy,
    output logic             result_valid,
    output frt_pkg::frt_out_t result,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data
);
    import frt_pkg::*;

    logic [15:0] chunk_reg, stale_reg, sweep_reg;
    logic        q_full, q_ne, push, pop;
    frt_job_t    push_job, head;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg <= 16'd1400;
            stale_reg <= 16'd1000;
            sweep_reg <= 16'd500;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CHUNK: chunk_reg <= cfg_data;
                REG_STALE: stale_reg <= cfg_data;
                REG_SWEEP: sweep_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    frt_front u_front (
        .clk, .rst_n, .start, .in_item, .q_full,
        .chunk_bytes(chunk_reg), .sweep_ticks(sweep_reg),
        .busy, .job_push(push), .job(push_job)
    );

    frt_queue u_queue (
        .clk, .rst_n, .push, .push_job, .pop,
        .full(q_full), .not_empty(q_ne), .head
    );

    frt_back u_back (
        .clk, .rst_n, .job_valid(q_ne), .job(head), .stale_ticks(stale_reg),
        .pop, .done(result_valid), .result
    );

    `FRT_ASSERT_NEXT(a_hdr_result, clk, rst_n, start && !busy && !in_item.mode && !q_ne, q_ne, "header not queued")
    `FRT_ASSERT_NEXT(a_result, clk, rst_n, q_ne, result_valid, "queued job gave no result")
    `FRT_ASSERT_IMPL(a_status, clk, rst_n, result_valid, result.status <= ST_TOOMANY, "bad status")
endmodule

>>> bench/frt_checker.sv
`timescale 1ns / 100ps
// Checker for the fragment reassembly tracker: predicts each header's result
// and compares it with the block's output. Depends on frt_pkg.
module frt_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  frt_pkg::frt_in_t  in_item,
    input  logic              result_valid,
    input  frt_pkg::frt_out_t result,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output int                fail_count,
    output int                pending
);
    import frt_pkg::*;

    // Predictor copy of registers and table
    logic [15:0] chunk_reg, stale_reg, sweep_reg;
    logic        tbl_valid [SLOTS];
    logic [15:0] tbl_image [SLOTS];
    logic [15:0] tbl_total [SLOTS];
    logic [15:0] tbl_bytes [SLOTS];
    logic [6:0]  tbl_got   [SLOTS];
    logic [63:0] tbl_seen  [SLOTS];
    logic [31:0] tbl_first [SLOTS];
    logic [31:0] tbl_last  [SLOTS];
    logic [31:0] now_ticks, last_sweep;

    frt_out_t expected_results[$];

    assign pending = expected_results.size();

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    // Work out the result of one fragment header and update the table
    task automatic predict_fragment(input frt_in_t hdr, output frt_out_t res);
        int          slot;
        logic [63:0] off;
        slot = -1;
        res  = '0;
        if (now_ticks - last_sweep > {16'd0, sweep_reg})
        begin
            for (int s = 0; s < SLOTS; s++)
                if (tbl_valid[s] && (now_ticks - tbl_last[s] > {16'd0, stale_reg}))
                    tbl_valid[s] = 1'b0;
            last_sweep = now_ticks;
        end
        for (int s = 0; s < SLOTS; s++)
            if (slot < 0 && tbl_valid[s] && tbl_image[s] == hdr.image_id)
                slot = s;
        if (slot < 0)
        begin
            if (hdr.frag_total > MAX_FRAGS)
                res.status = ST_TOOMANY;
            else
            begin
                for (int s = 0; s < SLOTS; s++)
                    if (slot < 0 && !tbl_valid[s])
                        slot = s;
                if (slot < 0)
                    res.status = ST_FULL;
                else
                begin
                    tbl_valid[slot] = 1'b1;
                    tbl_image[slot] = hdr.image_id;
                    tbl_total[slot] = hdr.frag_total;
                    tbl_bytes[slot] = hdr.image_bytes;
                    tbl_got[slot]   = '0;
                    tbl_seen[slot]  = '0;
                    tbl_first[slot] = now_ticks;
                end
            end
        end
        if (slot >= 0)
        begin
            tbl_last[slot] = now_ticks;
            res.slot_index = slot[2:0];
            if (hdr.frag_index >= tbl_total[slot])
                res.status = ST_RANGE;
            else if (tbl_seen[slot][hdr.frag_index[5:0]])
                res.status = ST_DUP;
            else
            begin
                off = 64'(hdr.frag_index) * 64'(chunk_reg);
                if (off + 64'(hdr.payload_bytes) > 64'(tbl_bytes[slot]))
                    res.status = ST_OVERFLOW;
                else
                begin
                    res.status       = ST_STORED;
                    res.write_offset = off[15:0];
                    res.write_length = hdr.payload_bytes;
                    tbl_seen[slot][hdr.frag_index[5:0]] = 1'b1;
                    tbl_got[slot]++;
                end
            end
            if (16'(tbl_got[slot]) == tbl_total[slot])
            begin
                res.image_complete = 1'b1;
                res.done_bytes     = tbl_bytes[slot];
                res.latency_ticks  = now_ticks - tbl_first[slot];
                tbl_valid[slot]    = 1'b0;
            end
        end
    endtask

    // Watch all channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        frt_out_t exp_res;
        if (!rst_n)
        begin
            chunk_reg  = 16'd1400;
            stale_reg  = 16'd1000;
            sweep_reg  = 16'd500;
            now_ticks  = '0;
            last_sweep = '0;
            for (int s = 0; s < SLOTS; s++)
                tbl_valid[s] = 1'b0;
            expected_results.delete();
        end
        else
        begin
            // result side first: it belongs to transactions already predicted
            if (result_valid)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with no transaction pending");
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (result.status !== exp_res.status)
                        report_mismatch($sformatf("status %0d exp %0d",
                                        result.status, exp_res.status));
                    if (result.write_offset !== exp_res.write_offset)
                        report_mismatch($sformatf("write_offset %0d exp %0d",
                                        result.write_offset, exp_res.write_offset));
                    if (result.write_length !== exp_res.write_length)
                        report_mismatch($sformatf("write_length %0d exp %0d",
                                        result.write_length, exp_res.write_length));
                    if (result.slot_index !== exp_res.slot_index)
                        report_mismatch($sformatf("slot_index %0d exp %0d",
                                        result.slot_index, exp_res.slot_index));
                    if (result.image_complete !== exp_res.image_complete)
                        report_mismatch($sformatf("image_complete %0d exp %0d",
                                        result.image_complete, exp_res.image_complete));
                    if (result.done_bytes !== exp_res.done_bytes)
                        report_mismatch($sformatf("done_bytes %0d exp %0d",
                                        result.done_bytes, exp_res.done_bytes));
                    if (result.latency_ticks !== exp_res.latency_ticks)
                        report_mismatch($sformatf("latency_ticks %0d exp %0d",
                                        result.latency_ticks, exp_res.latency_ticks));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CHUNK: chunk_reg = cfg_data;
                    REG_STALE: stale_reg = cfg_data;
                    REG_SWEEP: sweep_reg = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                if (in_item.mode)
                    now_ticks++;
                else
                begin
                    predict_fragment(in_item, exp_res);
                    expected_results.push_back(exp_res);
                end
            end
        end
    end

    initial fail_count = 0;
endmodule

>>> bench/fragment_reassembly_tracker_tb.sv
`timescale 1ns / 100ps
// Top of the fragment reassembly tracker bench: clock, reset, stimulus, verdict.
// Depends on frt_pkg, frt_checker and the block itself.
module fragment_reassembly_tracker_tb;
    import frt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic      clk;
    logic      rst_n;
    logic      start;
    frt_in_t   in_item;
    logic      busy;
    logic      result_valid;
    frt_out_t  result;
    logic      cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    int        fail_count;
    int        pending;
    int        cycles = 0;
    int        tick_pct;
    int        noise_pct;

    fragment_reassembly_tracker i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .in_item(in_item), .busy(busy),
        .result_valid(result_valid), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    frt_checker i_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
        .result_valid(result_valid), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Run watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Issue one transaction, hold until taken, then an optional gap
    task automatic send(input frt_in_t it);
        int gap;
        start   <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (busy);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: gap = 0;
            5, 6, 7:       gap = $urandom_range(1, 3);
            8:             gap = $urandom_range(4, 8);
            default:       gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : 0;
        endcase
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic header(input int id, input int idx, input int total,
                          input int bytes, input int pay);
        frt_in_t it;
        it.mode          = 1'b0;
        it.image_id      = 16'(id);
        it.frag_index    = 16'(idx);
        it.frag_total    = 16'(total);
        it.image_bytes   = 16'(bytes);
        it.payload_bytes = 16'(pay);
        send(it);
    endtask

    task automatic tick();
        frt_in_t     it;
        logic [95:0] rnd;
        rnd     = {$urandom, $urandom, $urandom};
        it      = rnd[$bits(frt_in_t)-1:0];
        it.mode = 1'b1;
        send(it);
    endtask

    // Wait until every result has come, plus the pipeline depth
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One register write, then the port is left idle before the task returns
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Random phase: mostly well-formed images from a small id pool
    task automatic random_phase(input int count, input logic [15:0] chunk);
        frt_in_t     it;
        logic [95:0] rnd;
        int          total;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < tick_pct)
                tick();
            else if ($urandom_range(0, 99) < noise_pct)
            begin
                rnd     = {$urandom, $urandom, $urandom};
                it      = rnd[$bits(frt_in_t)-1:0];
                it.mode = 1'b0;
                if (it.payload_bytes == 0)
                    it.payload_bytes = 16'd1;
                send(it);
            end
            else
            begin
                total = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 70)
                                                     : $urandom_range(0, 6);
                header($urandom_range(0, 11),
                       ($urandom_range(0, 9) == 0) ? $urandom_range(0, 80)
                                                   : $urandom_range(0, (total > 0) ? total - 1 : 0),
                       total,
                       ($urandom_range(0, 7) == 0) ? $urandom : total * chunk,
                       ($urandom_range(0, 5) == 0) ? $urandom_range(1, 65535) : chunk);
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset register values
        tick();
        header(100, 0, 0, 500, 1);            // zero fragment count
        header(101, 0, 65, 1000, 1);          // too many fragments
        header(102, 0, 64, 65535, 1400);      // stored
        header(102, 0, 64, 65535, 1400);      // duplicate
        header(102, 64, 64, 65535, 1400);     // index past count
        header(102, 46, 64, 65535, 1400);     // overflows stored size
        header(102, 1, 3, 0, 65535);          // later fields ignored, overflow
        header(300, 0, 2, 2800, 1400);
        tick();
        tick();
        header(300, 1, 2, 2800, 1400);        // completes with latency
        for (int k = 0; k < 8; k++)
            header(200 + k, 0, 2, 2800, 1);   // last one finds the table full
        header(65535, 65535, 65535, 65535, 65535);
        drain();

        // Random phases over several register settings
        tick_pct  = 20;
        noise_pct = 10;
        write_reg(REG_CHUNK, 16'd1);
        write_reg(REG_STALE, 16'd3);
        write_reg(REG_SWEEP, 16'd2);
        random_phase(300, 16'd1);
        drain();
        write_reg(REG_CHUNK, 16'd65535);
        write_reg(REG_STALE, 16'd65535);
        write_reg(REG_SWEEP, 16'd65535);
        random_phase(250, 16'd65535);
        drain();
        tick_pct = 35;
        write_reg(REG_CHUNK, 16'd7);
        write_reg(REG_STALE, 16'd1);
        write_reg(REG_SWEEP, 16'd1);
        random_phase(250, 16'd7);
        drain();
        tick_pct = 15;
        write_reg(REG_CHUNK, 16'd200);
        write_reg(REG_STALE, 16'd20);
        write_reg(REG_SWEEP, 16'd10);
        random_phase(300, 16'd200);
        drain();
        write_reg(REG_CHUNK, 16'd1400);
        write_reg(REG_STALE, 16'd6);
        write_reg(REG_SWEEP, 16'd3);
        random_phase(280, 16'd1400);

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl
rtl/frt_pkg.sv
rtl/frt_front.sv
rtl/frt_queue.sv
rtl/frt_back.sv
rtl/fragment_reassembly_tracker.sv
bench/frt_checker.sv
bench/fragment_reassembly_tracker_tb.sv
